// ===== hw/rtl/slfe_pkg.sv =====
package slfe_pkg;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;  // width of frame_len and byte_index on the ports

  // header byte positions after the sync pair
  localparam logic [2:0] HDR_PACKET_ID = 3'd0;
  localparam logic [2:0] HDR_FRAG_SEQ  = 3'd1;
  localparam logic [2:0] HDR_MORE      = 3'd2;
  localparam logic [2:0] HDR_LEN_LO    = 3'd3;
  localparam logic [2:0] HDR_LEN_HI    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT_FIRST  = 3'd0,
    PH_HUNT_SECOND = 3'd1,
    PH_HEADER      = 3'd2,
    PH_PAYLOAD     = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROPPED = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    packet_id;
    logic [BYTE_W-1:0]    frag_seq;
    logic [BYTE_W-1:0]    more_frags;
    logic [FIELD_W-1:0]   frame_len;
    logic [BYTE_W-1:0]    data_byte;
    logic [FIELD_W-1:0]   byte_index;
    logic                 last;
  } slfe_res_t;

endpackage

// ===== hw/rtl/slfe_parse.sv =====
module slfe_parse import slfe_pkg::*; #(
  parameter int LEN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_fire,
  input  logic [BYTE_W-1:0]  rx_byte,
  input  logic [BYTE_W-1:0]  sync_first,
  input  logic [BYTE_W-1:0]  sync_second,
  input  logic [FIELD_W-1:0] max_len,
  output logic               res_valid,
  output slfe_res_t          res
);

  phase_t               phase_r, phase_nxt;
  logic [2:0]           hcnt_r, hcnt_nxt;
  logic [BYTE_W-1:0]    id_r, id_nxt;
  logic [BYTE_W-1:0]    seq_r, seq_nxt;
  logic [BYTE_W-1:0]    more_r, more_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic [LEN_WIDTH-1:0] pcnt_r, pcnt_nxt;
  logic                 is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_FIRST;
      hcnt_r  <= '0;
      id_r    <= '0;
      seq_r   <= '0;
      more_r  <= '0;
      len_r   <= '0;
      pcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      id_r    <= id_nxt;
      seq_r   <= seq_nxt;
      more_r  <= more_nxt;
      len_r   <= len_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  // index + 1 reaching the declared length ends the payload
  assign is_last = ({1'b0, pcnt_r} + {{LEN_WIDTH{1'b0}}, 1'b1}) >= {1'b0, len_r};

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    id_nxt    = id_r;
    seq_nxt   = seq_r;
    more_nxt  = more_r;
    len_nxt   = len_r;
    pcnt_nxt  = pcnt_r;
    res_valid = 1'b0;
    res.kind  = KIND_PAYLOAD;
    res.data_byte  = '0;
    res.byte_index = '0;
    res.last       = 1'b0;

    if (byte_fire) begin
      unique case (phase_r)
        PH_HUNT_FIRST: begin
          if (rx_byte == sync_first) phase_nxt = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          // second sync wins over a repeated first sync
          if (rx_byte == sync_second) begin
            phase_nxt = PH_HEADER;
            hcnt_nxt  = '0;
          end else if (rx_byte != sync_first) begin
            phase_nxt = PH_HUNT_FIRST;
          end
        end
        PH_HEADER: begin
          unique case (hcnt_r)
            HDR_PACKET_ID: id_nxt   = rx_byte;
            HDR_FRAG_SEQ:  seq_nxt  = rx_byte;
            HDR_MORE:      more_nxt = rx_byte;
            HDR_LEN_LO:    len_nxt  = LEN_WIDTH'(rx_byte);
            default:       len_nxt  = LEN_WIDTH'({rx_byte, len_r[BYTE_W-1:0]});
          endcase
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_r == HDR_LEN_HI) begin
            hcnt_nxt = '0;
            pcnt_nxt = '0;
            if (FIELD_W'(len_nxt) > max_len) begin
              phase_nxt = PH_HUNT_FIRST;
              res_valid = 1'b1;
              res.kind  = KIND_DROPPED;
              res.last  = 1'b1;
            end else if (len_nxt == '0) begin
              phase_nxt = PH_HUNT_FIRST;
              res_valid = 1'b1;
              res.kind  = KIND_EMPTY;
              res.last  = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid      = 1'b1;
          res.kind       = KIND_PAYLOAD;
          res.data_byte  = rx_byte;
          res.byte_index = FIELD_W'(pcnt_r);
          res.last       = is_last;
          if (is_last) begin
            phase_nxt = PH_HUNT_FIRST;
            pcnt_nxt  = '0;
          end else begin
            pcnt_nxt  = pcnt_r + LEN_WIDTH'(1);
          end
        end
        default: begin
          phase_nxt = PH_HUNT_FIRST;
          hcnt_nxt  = '0;
          pcnt_nxt  = '0;
        end
      endcase
    end

    res.packet_id  = id_nxt;
    res.frag_seq   = seq_nxt;
    res.more_frags = more_nxt;
    res.frame_len  = FIELD_W'(len_nxt);
  end

endmodule

// ===== hw/rtl/sync_length_frame_extractor.sv =====
// Byte-serial deframer for frames of the form: sync_first, sync_second, packet id,
// fragment sequence, more-fragments byte, length low, length high, payload.
// in_*: one received byte per request. out_*: one result per payload byte, or one
// empty-frame / dropped-oversize report when the header ends; header and hunt bytes
// give no result. cfg_*: register writes (0 sync_first, 1 sync_second,
// 2 max_payload_len); cfg_ready is always high, other indexes are ignored.
// Throughput: one byte per cycle unless the output stalls. Latency: a result appears on
// out_* the cycle after the byte that causes it is taken; the parser state and the
// output register are the only stages.
// When the receiver stalls, the result holds in the output register and in_ready
// drops until it is taken; a new byte is taken in the same cycle the held result
// leaves. Reset (rst_n low, synchronous) returns the parser to hunting for the
// first sync byte, empties the output register and restores the register defaults
// (sync bytes 0, maximum length 65535). LEN_WIDTH sets the length and byte counter
// width; lengths are kept modulo 2**LEN_WIDTH.
module sync_length_frame_extractor import slfe_pkg::*; #(
  parameter int LEN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [BYTE_W-1:0]  out_packet_id,
  output logic [BYTE_W-1:0]  out_frag_seq,
  output logic [BYTE_W-1:0]  out_more_frags,
  output logic [FIELD_W-1:0] out_frame_len,
  output logic [BYTE_W-1:0]  out_data_byte,
  output logic [FIELD_W-1:0] out_byte_index,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [FIELD_W-1:0] cfg_data
);

  logic [BYTE_W-1:0]  sync_first_r, sync_first_nxt;
  logic [BYTE_W-1:0]  sync_second_r, sync_second_nxt;
  logic [FIELD_W-1:0] max_len_r, max_len_nxt;
  logic               out_valid_r, out_valid_nxt;
  slfe_res_t          out_res_r;
  logic               in_fire;
  logic               res_valid;
  slfe_res_t          res;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;

  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    max_len_nxt     = max_len_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_nxt  = cfg_data[BYTE_W-1:0];
        CFG_SYNC_SECOND: sync_second_nxt = cfg_data[BYTE_W-1:0];
        CFG_MAX_LEN:     max_len_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= '0;
      sync_second_r <= '0;
      max_len_r     <= '1;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      max_len_r     <= max_len_nxt;
    end
  end

  slfe_parse #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (in_fire),
    .rx_byte     (in_rx_byte),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .max_len     (max_len_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // load on a new result, drop once the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_res_r.kind;
  assign out_packet_id  = out_res_r.packet_id;
  assign out_frag_seq   = out_res_r.frag_seq;
  assign out_more_frags = out_res_r.more_frags;
  assign out_frame_len  = out_res_r.frame_len;
  assign out_data_byte  = out_res_r.data_byte;
  assign out_byte_index = out_res_r.byte_index;
  assign out_last       = out_res_r.last;

endmodule

// ===== hw/rtl/slfe_check.sv =====
module slfe_check import slfe_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [FIELD_W-1:0] out_frame_len,
  input logic [BYTE_W-1:0]  out_data_byte,
  input logic [FIELD_W-1:0] out_byte_index,
  input logic               out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data_byte)
      && $stable(out_byte_index) && $stable(out_last) && $stable(out_frame_len))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |->
      out_last && out_data_byte == '0 && out_byte_index == '0)
    else $error("empty or dropped report malformed");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PAYLOAD |-> out_byte_index < out_frame_len)
    else $error("payload index beyond frame length");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PAYLOAD |->
      out_last == (({1'b0, out_byte_index} + 17'd1) == {1'b0, out_frame_len}))
    else $error("last mark not on final payload byte");

endmodule

bind sync_length_frame_extractor slfe_check u_slfe_check (.*);

// ===== dv/sync_length_frame_extractor_tb.sv =====
`timescale 1ns / 100ps

module sync_length_frame_extractor_tb;
  import slfe_pkg::*;

  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         ITEMS_PER_PHASE = 240;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [BYTE_W-1:0]  out_packet_id;
  logic [BYTE_W-1:0]  out_frag_seq;
  logic [BYTE_W-1:0]  out_more_frags;
  logic [FIELD_W-1:0] out_frame_len;
  logic [BYTE_W-1:0]  out_data_byte;
  logic [FIELD_W-1:0] out_byte_index;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;

  sync_length_frame_extractor u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_packet_id (out_packet_id),
    .out_frag_seq  (out_frag_seq),
    .out_more_frags(out_more_frags),
    .out_frame_len (out_frame_len),
    .out_data_byte (out_data_byte),
    .out_byte_index(out_byte_index),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // deframer mirror: configuration and parser state
  logic [7:0]   sync_a = 8'h00;
  logic [7:0]   sync_b = 8'h00;
  logic [15:0]  len_limit = 16'hFFFF;
  phase_t       hunt_phase = PH_HUNT_FIRST;
  logic [2:0]   hdr_pos = '0;
  logic [7:0]   hdr_pid = '0;
  logic [7:0]   hdr_fseq = '0;
  logic [7:0]   hdr_more = '0;
  logic [15:0]  hdr_len = '0;
  logic [15:0]  payload_pos = '0;

  slfe_res_t    pending_results[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           sender_idle = 1'b0;
  bit           receiver_idle = 1'b0;

  function automatic void push_result(kind_t k, logic [7:0] d, logic [15:0] idx, logic lst);
    slfe_res_t r;
    r.kind       = k;
    r.packet_id  = hdr_pid;
    r.frag_seq   = hdr_fseq;
    r.more_frags = hdr_more;
    r.frame_len  = hdr_len;
    r.data_byte  = d;
    r.byte_index = idx;
    r.last       = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic is_last;
    case (hunt_phase)
      PH_HUNT_FIRST: begin
        if (b == sync_a) hunt_phase = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        // second sync wins when both sync values are equal
        if (b == sync_b) begin
          hunt_phase = PH_HEADER;
          hdr_pos    = '0;
        end else if (b != sync_a) begin
          hunt_phase = PH_HUNT_FIRST;
        end
      end
      PH_HEADER: begin
        case (hdr_pos)
          HDR_PACKET_ID: hdr_pid  = b;
          HDR_FRAG_SEQ:  hdr_fseq = b;
          HDR_MORE:      hdr_more = b;
          HDR_LEN_LO:    hdr_len  = {8'h00, b};
          default:       hdr_len  = hdr_len | {b, 8'h00};
        endcase
        if (hdr_pos != HDR_LEN_HI) begin
          hdr_pos = hdr_pos + 3'd1;
        end else begin
          hdr_pos     = '0;
          payload_pos = '0;
          if (hdr_len > len_limit) begin
            hunt_phase = PH_HUNT_FIRST;
            push_result(KIND_DROPPED, 8'h00, 16'h0000, 1'b1);
          end else if (hdr_len == 16'h0000) begin
            hunt_phase = PH_HUNT_FIRST;
            push_result(KIND_EMPTY, 8'h00, 16'h0000, 1'b1);
          end else begin
            hunt_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        is_last = ({1'b0, payload_pos} + 17'd1 >= {1'b0, hdr_len});
        push_result(KIND_PAYLOAD, b, payload_pos, is_last);
        payload_pos = payload_pos + 16'd1;
        if (is_last) begin
          hunt_phase  = PH_HUNT_FIRST;
          payload_pos = '0;
        end
      end
      default: begin
        hunt_phase  = PH_HUNT_FIRST;
        hdr_pos     = '0;
        payload_pos = '0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    deframe_byte(b);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_SYNC_FIRST:  sync_a    = data[7:0];
      CFG_SYNC_SECOND: sync_b    = data[7:0];
      CFG_MAX_LEN:     len_limit = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] max_len);
    write_reg(CFG_SYNC_FIRST, {8'h00, s1});
    write_reg(CFG_SYNC_SECOND, {8'h00, s2});
    write_reg(CFG_MAX_LEN, max_len);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every expected result has been taken
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_frame(input int extra_sync, input logic [15:0] len);
    int n_payload;
    n_payload = (len != 0 && len <= len_limit) ? int'(len) : 0;
    repeat (extra_sync) send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (n_payload) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_traffic(input int n_items);
    int          count;
    int unsigned pick;
    int          extra;
    logic [15:0] len;
    logic [7:0]  b;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise that keeps the hunt idle
        do b = 8'($urandom_range(0, 255)); while (b == sync_a);
        send_byte(b);
      end else if (pick < 14) begin
        // first sync followed by a wrong byte
        do b = 8'($urandom_range(0, 255)); while (b == sync_a || b == sync_b);
        send_byte(sync_a);
        send_byte(b);
      end else if (pick < 17) begin
        wait_results_drained();
      end else begin
        extra = (sync_a != sync_b && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        pick  = $urandom_range(0, 99);
        if (pick < 10)
          len = 16'h0000;
        else if (pick < 13)
          len = 16'($urandom_range(256, 300));
        else if (pick < 25 && len_limit != 16'hFFFF)
          len = 16'($urandom_range(int'(len_limit) + 1, 65535));
        else
          len = 16'($urandom_range(1, 16));
        send_frame(extra, len);
        count += 7 + extra + ((len != 0 && len <= len_limit) ? int'(len) : 0);
      end
    end
  endtask

  task automatic test_reset_defaults();
    // defaults: both sync bytes zero, no length limit
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_results_drained();
  endtask

  task automatic test_sync_hunt();
    write_reg(CFG_UNUSED, 16'hFFFF);
    set_config(8'hFF, 8'h00, 16'hFFFE);
    // repeated first sync, then a wrong second byte drops back to hunting
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h34);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    // largest length, one above the limit
    send_byte(8'hFF);
    send_byte(8'hFF);
    wait_results_drained();
  endtask

  task automatic test_equal_sync_empty();
    set_config(8'h3C, 8'h3C, 16'hFFFF);
    send_byte(8'h3C);
    send_byte(8'h3C);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_results_drained();
  endtask

  task automatic test_random_phases();
    logic [7:0] s;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          sender_idle = 1'b0; receiver_idle = 1'b0;
          set_config(8'h00, 8'hFF, 16'hFFFF);
        end
        1: begin
          sender_idle = 1'b1; receiver_idle = 1'b1;
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'h0000);
        end
        2: begin
          sender_idle = 1'b1; receiver_idle = 1'b0;
          s = 8'($urandom_range(0, 255));
          set_config(s, s, 16'($urandom_range(1, 20)));
        end
        3: begin
          sender_idle = 1'b0; receiver_idle = 1'b1;
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF);
        end
        default: begin
          sender_idle = 1'b1; receiver_idle = 1'b1;
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 300)));
        end
      endcase
      random_traffic(ITEMS_PER_PHASE);
      wait_results_drained();
    end
  endtask

  // result receiver with random back-pressure while receiver_idle is set
  initial begin
    int n;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = receiver_idle ? $urandom_range(0, 15) : 0;
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    slfe_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: kind %0d data 0x%0h", out_kind, out_data_byte);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("kind", 16'(exp_r.kind), 16'(out_kind));
        check_field("packet_id", 16'(exp_r.packet_id), 16'(out_packet_id));
        check_field("frag_seq", 16'(exp_r.frag_seq), 16'(out_frag_seq));
        check_field("more_frags", 16'(exp_r.more_frags), 16'(out_more_frags));
        check_field("frame_len", exp_r.frame_len, out_frame_len);
        check_field("data_byte", 16'(exp_r.data_byte), 16'(out_data_byte));
        check_field("byte_index", exp_r.byte_index, out_byte_index);
        check_field("last", 16'(exp_r.last), 16'(out_last));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request taken for %0d cycles", STALL_LIMIT);
      $display("** sync_length_frame_extractor: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_sync_hunt();
    test_equal_sync_empty();
    test_random_phases();
    wait_results_drained();
    if (mismatches == 0)
      $display("** sync_length_frame_extractor: PASSED **");
    else
      $display("** sync_length_frame_extractor: FAILED **");
    $finish;
  end

endmodule
